>>> rtl/midi_note_voice_allocator_defines.svh
// Assertion macros for the voice allocator. Each expects clk and rst in scope.
`ifndef MIDI_NOTE_VOICE_ALLOCATOR_DEFINES_SVH
`define MIDI_NOTE_VOICE_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MNVA_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MNVA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/mnva_pkg.sv
`default_nettype none
package mnva_pkg;

  localparam int NUM_VOICES_DEF = 32;
  localparam int MIDI_CHANNELS  = 16;

  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_SOUND_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOICES_IN_USE = 2'd1;
  localparam logic [5:0] VOICES_IN_USE_RESET = 6'd32;

  // Divider geometry for the period: the sample rate needs 15 bits and the
  // largest phase step 14.
  localparam int DIV_DVD_W = 15;
  localparam int DIV_DVS_W = 14;
  localparam int DIV_CNT_W = $clog2(DIV_DVD_W);

  localparam logic [DIV_DVD_W-1:0] SAMPLE_RATE = 15'd22050;

  // Amplitude scaling: velocity to percent, percent to full-scale level.
  localparam int VEL_MAX   = 127;
  localparam int PCT_SCALE = 100;
  localparam int AMP_FULL  = 32767;

  typedef enum logic [2:0] {
    OUT_IGNORED  = 3'd0,
    OUT_STARTED  = 3'd1,
    OUT_STOPPED  = 3'd2,
    OUT_NO_FREE  = 3'd3,
    OUT_BAD_NOTE = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV_PERIOD,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic div_go;
    logic latch_period;
  } dp_cmd_t;

  typedef struct packed {
    logic start_ok;
    logic div_done;
  } dp_status_t;

  // Phase step per note number.
  localparam logic [DIV_DVS_W-1:0] NOTE_STEP [128] = '{
    14'h0008, 14'h0008, 14'h0009, 14'h0009, 14'h000A, 14'h000A, 14'h000B, 14'h000C,
    14'h000C, 14'h000D, 14'h000E, 14'h000F, 14'h0010, 14'h0011, 14'h0012, 14'h0013,
    14'h0014, 14'h0015, 14'h0017, 14'h0018, 14'h0019, 14'h001B, 14'h001D, 14'h001E,
    14'h0020, 14'h0022, 14'h0024, 14'h0026, 14'h0029, 14'h002B, 14'h002E, 14'h0031,
    14'h0033, 14'h0037, 14'h003A, 14'h003D, 14'h0041, 14'h0045, 14'h0049, 14'h004D,
    14'h0052, 14'h0057, 14'h005C, 14'h0062, 14'h0067, 14'h006E, 14'h0074, 14'h007B,
    14'h0082, 14'h008A, 14'h0092, 14'h009B, 14'h00A4, 14'h00AE, 14'h00B9, 14'h00C4,
    14'h00CF, 14'h00DC, 14'h00E9, 14'h00F6, 14'h0105, 14'h0115, 14'h0125, 14'h0137,
    14'h0149, 14'h015D, 14'h0172, 14'h0188, 14'h019F, 14'h01B8, 14'h01D2, 14'h01ED,
    14'h020B, 14'h022A, 14'h024B, 14'h026E, 14'h0293, 14'h02BA, 14'h02E4, 14'h0310,
    14'h033E, 14'h0370, 14'h03A4, 14'h03DB, 14'h0416, 14'h0454, 14'h0496, 14'h04DC,
    14'h0526, 14'h0574, 14'h05C8, 14'h0620, 14'h067D, 14'h06E0, 14'h0748, 14'h07B7,
    14'h082D, 14'h08A9, 14'h092D, 14'h09B9, 14'h0A4D, 14'h0AE9, 14'h0B90, 14'h0C40,
    14'h0CFA, 14'h0DC0, 14'h0E91, 14'h0F6F, 14'h105A, 14'h1153, 14'h125A, 14'h1372,
    14'h149A, 14'h15D3, 14'h1720, 14'h1880, 14'h19F5, 14'h1B80, 14'h1D22, 14'h1EDE,
    14'h20B4, 14'h22A6, 14'h24B5, 14'h26E4, 14'h2934, 14'h2BA7, 14'h2E40, 14'h3100
  };

endpackage
`default_nettype wire

>>> rtl/mnva_div.sv
`default_nettype none
module mnva_div
  import mnva_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 go,
  input  wire logic [DIV_DVD_W-1:0] dividend,
  input  wire logic [DIV_DVS_W-1:0] divisor,
  output logic      [DIV_DVD_W-1:0] quotient,
  output logic                      done
);

  // Restoring division, one quotient bit per cycle.
  logic [DIV_DVS_W-1:0] rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 running;
  logic [DIV_DVS_W:0]   trial;
  logic                 fits;
  logic                 last;

  always_comb begin
    trial = {rem, quotient[DIV_DVD_W-1]};
    fits  = trial >= {1'b0, divisor};
    last  = (cnt == DIV_CNT_W'(DIV_DVD_W - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (go) begin
      quotient <= dividend;
      rem      <= '0;
      cnt      <= '0;
      running  <= 1'b1;
      done     <= 1'b0;
    end else if (running) begin
      quotient <= {quotient[DIV_DVD_W-2:0], fits};
      rem      <= fits ? DIV_DVS_W'(trial - {1'b0, divisor}) : trial[DIV_DVS_W-1:0];
      cnt      <= cnt + 1'b1;
      running  <= !last;
      done     <= last;
    end else begin
      done <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/mnva_datapath.sv
`default_nettype none
module mnva_datapath
  import mnva_pkg::*;
#(
  parameter int NUM_VOICES = NUM_VOICES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire dp_cmd_t    cmd,
  output dp_status_t      status,
  input  wire logic       sound_enable,
  input  wire logic [5:0] voices_in_use,
  input  wire logic [7:0] status_byte,
  input  wire logic [7:0] note_number,
  input  wire logic [6:0] velocity,
  output logic [2:0]      outcome,
  output logic            stop_valid,
  output logic [4:0]      stop_voice,
  output logic            start_valid,
  output logic [4:0]      start_voice,
  output logic [11:0]     period_samples,
  output logic [10:0]     high_samples,
  output logic [14:0]     amplitude
);

  localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam logic [6:0] NUM_VOICES_7 = 7'(NUM_VOICES);

  // Captured message.
  logic [7:0] status_r;
  logic [7:0] note_r;
  logic [6:0] vel_r;

  // Allocation state.
  logic [NUM_VOICES-1:0] voice_busy;
  logic [MIDI_CHANNELS-1:0] ch_valid;
  logic [VIDX_W-1:0] ch_voice [MIDI_CHANNELS];

  logic [3:0]            cmd_code;
  logic [3:0]            ch;
  logic                  do_release;
  logic                  note_on;
  logic                  held;
  logic [VIDX_W-1:0]     held_voice;
  logic [NUM_VOICES-1:0] rel_mask;
  logic [NUM_VOICES-1:0] busy_rel;
  logic [NUM_VOICES-1:0] avail;
  logic [NUM_VOICES-1:0] lowest;
  logic [VIDX_W-1:0]     free_idx;
  logic                  found;
  logic                  start_ok;
  logic [6:0]            n_active;
  outcome_t              outcome_d;

  logic [DIV_DVD_W-1:0] div_q;
  logic                 div_done;

  // Level per velocity: the percentage of full velocity, then that share of
  // full scale, both truncated.
  logic [14:0] amp_rom [128];

  for (genvar i = 0; i < 128; i++) begin : g_amp_rom
    assign amp_rom[i] = 15'((((i * PCT_SCALE) / VEL_MAX) * AMP_FULL) / PCT_SCALE);
  end

  always_comb begin
    cmd_code   = status_r[7:4];
    ch         = status_r[3:0];
    note_on    = sound_enable && (cmd_code == CMD_NOTE_ON) && (vel_r != '0);
    do_release = sound_enable && ((cmd_code == CMD_NOTE_ON) || (cmd_code == CMD_NOTE_OFF));
    held       = ch_valid[ch];
    held_voice = ch_voice[ch];
    n_active   = ({1'b0, voices_in_use} < NUM_VOICES_7) ? {1'b0, voices_in_use} : NUM_VOICES_7;
    for (int v = 0; v < NUM_VOICES; v++) begin
      rel_mask[v] = (VIDX_W'(v) == held_voice);
    end
    busy_rel = (do_release && held) ? (voice_busy & ~rel_mask) : voice_busy;
    for (int v = 0; v < NUM_VOICES; v++) begin
      avail[v] = !busy_rel[v] && (7'(v) < n_active);
    end
    // Isolate the lowest free voice, then encode it.
    lowest   = avail & (~avail + NUM_VOICES'(1));
    free_idx = '0;
    for (int v = 0; v < NUM_VOICES; v++) begin
      free_idx = free_idx | (lowest[v] ? VIDX_W'(v) : '0);
    end
    found    = |avail;
    start_ok = note_on && !note_r[7] && found;

    if (!do_release) begin
      outcome_d = OUT_IGNORED;
    end else if (note_on) begin
      if (note_r[7]) begin
        outcome_d = OUT_BAD_NOTE;
      end else if (found) begin
        outcome_d = OUT_STARTED;
      end else begin
        outcome_d = OUT_NO_FREE;
      end
    end else begin
      outcome_d = OUT_STOPPED;
    end
  end

  // The period is the sample rate over the note's phase step.
  mnva_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (SAMPLE_RATE),
    .divisor  (NOTE_STEP[note_r[6:0]]),
    .quotient (div_q),
    .done     (div_done)
  );

  assign status = '{start_ok: start_ok, div_done: div_done};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      status_r <= status_byte;
      note_r   <= note_number;
      vel_r    <= velocity;
    end
    if (rst) begin
      voice_busy <= '0;
      ch_valid   <= '0;
    end else if (cmd.eval && do_release) begin
      voice_busy   <= start_ok ? (busy_rel | lowest) : busy_rel;
      ch_valid[ch] <= start_ok;
    end
    if (cmd.eval && start_ok) begin
      ch_voice[ch] <= free_idx;
    end
    if (cmd.eval) begin
      outcome        <= outcome_d;
      stop_valid     <= do_release && held;
      stop_voice     <= (do_release && held) ? 5'(held_voice) : '0;
      start_valid    <= start_ok;
      start_voice    <= start_ok ? 5'(free_idx) : '0;
      period_samples <= '0;
      high_samples   <= '0;
      amplitude      <= start_ok ? amp_rom[vel_r] : '0;
    end else if (cmd.latch_period) begin
      period_samples <= div_q[11:0];
      high_samples   <= div_q[11:1];
    end
  end

endmodule
`default_nettype wire

>>> rtl/mnva_ctrl.sv
`default_nettype none
module mnva_ctrl
  import mnva_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd,
  output logic            busy,
  output logic            done
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (status.start_ok) begin
          cmd.div_go = 1'b1;
          state_next = ST_DIV_PERIOD;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_DIV_PERIOD: begin
        if (status.div_done) begin
          cmd.latch_period = 1'b1;
          state_next       = ST_RESULT;
        end
      end
      ST_RESULT: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/midi_note_voice_allocator.sv
// MIDI note voice allocator. Raise start with a MIDI short message on
// status_byte, note_number and velocity; the beat is taken at a clock edge
// where start is high and busy is low. Exactly one result comes back per
// message: done is high for a single cycle and the result ports are valid in
// that cycle only, so the receiver must take it then, as it cannot stall the
// block. One message is handled at a time. A message that starts no voice
// (ignored, release only, no free voice, bad note) goes through evaluation
// to the result state, where done is raised. A message that starts a voice
// also runs the radix-2 divider for 15 steps to form the period from the
// sample rate and the note's phase step; done follows once it is latched.
// The amplitude comes from a per-velocity table in the same cycle as the
// voice choice. Configuration is written through cfg_valid/cfg_ready while
// the block is idle, a rule on the user that it does not enforce; cfg_ready
// is always high. No clearing pass is needed after reset.
`default_nettype none
`include "midi_note_voice_allocator_defines.svh"
module midi_note_voice_allocator
  import mnva_pkg::*;
#(
  parameter int NUM_VOICES = NUM_VOICES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [7:0]            status_byte,
  input  wire logic [7:0]            note_number,
  input  wire logic [6:0]            velocity,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       done,
  output logic [2:0]                 outcome,
  output logic                       stop_valid,
  output logic [4:0]                 stop_voice,
  output logic                       start_valid,
  output logic [4:0]                 start_voice,
  output logic [11:0]                period_samples,
  output logic [10:0]                high_samples,
  output logic [14:0]                amplitude
);

  // Configuration registers. Writes to indexes past the list are dropped.
  logic       sound_enable;
  logic [5:0] voices_in_use;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_enable  <= 1'b0;
      voices_in_use <= VOICES_IN_USE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SOUND_ENABLE:  sound_enable  <= cfg_data[0];
        CFG_VOICES_IN_USE: voices_in_use <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  // The controller sequences capture, evaluation and the period division;
  // the datapath holds the voice table and the result registers.
  dp_cmd_t    cmd;
  dp_status_t dp_status;

  mnva_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (dp_status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  mnva_datapath #(
    .NUM_VOICES (NUM_VOICES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (dp_status),
    .sound_enable   (sound_enable),
    .voices_in_use  (voices_in_use),
    .status_byte    (status_byte),
    .note_number    (note_number),
    .velocity       (velocity),
    .outcome        (outcome),
    .stop_valid     (stop_valid),
    .stop_voice     (stop_voice),
    .start_valid    (start_valid),
    .start_voice    (start_voice),
    .period_samples (period_samples),
    .high_samples   (high_samples),
    .amplitude      (amplitude)
  );

  // An accepted beat must make the block busy in the next cycle.
  `MNVA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  // A result is only presented while the block still owns the message.
  `MNVA_ASSERT_SAME(a_done_busy, done, busy, "result presented while idle")
  // A started voice always reports the started outcome.
  `MNVA_ASSERT_SAME(a_start_outcome, done && start_valid, outcome == OUT_STARTED,
                    "start_valid without started outcome")
  // Without a start the tone fields read zero.
  `MNVA_ASSERT_SAME(a_no_start_zero, done && !start_valid,
                    period_samples == '0 && amplitude == '0 && start_voice == '0,
                    "tone fields nonzero without a start")

endmodule
`default_nettype wire
